>>> sv/domfr_pkg.sv
// Shared types and constants for the dominator and frontier block.
package domfr_pkg;

  // Field and bus widths
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned MASK_W    = 32;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 72;

  // Configuration register indexes
  localparam logic REG_BLOCK_COUNT = 1'b0;
  localparam logic REG_ENTRY_BLOCK = 1'b1;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 6'd32;
  localparam logic [IDX_W-1:0] ENTRY_BLOCK_RST = 5'd0;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_LOAD,
    S_SCAN,
    S_WRITE,
    S_EMIT
  } state_t;

  // Control of the shared mask unit
  typedef struct packed {
    logic take;   // predecessor bit set: fold the operand in
    logic front;  // frontier pass: OR in the non-strict part, else AND
  } alu_ctl_t;

endpackage

>>> sv/domfr_alu.sv
// Shared mask unit: folds one predecessor's dominator set into the accumulator.
module domfr_alu
  import domfr_pkg::*;
(
  input  alu_ctl_t          ctl,
  input  logic [MASK_W-1:0] acc,
  input  logic [MASK_W-1:0] operand,
  input  logic [MASK_W-1:0] strict,
  output logic [MASK_W-1:0] result
);

  // Intersect for dominators, collect non-strict dominators for frontiers
  always_comb begin
    if (!ctl.take) begin
      result = acc;
    end else if (ctl.front) begin
      result = acc | (operand & ~strict);
    end else begin
      result = acc & operand;
    end
  end

endmodule

>>> sv/dominator_and_frontier_sets.sv
// Top level: edge store, dominator fixed point, frontier pass and result stream.
// Edges are taken only in the idle state. After the last edge: an init state, then
// dominator passes over all blocks (repeated until no set changes, at most about n+1
// passes), one frontier pass over all blocks, then n results.
// Throughput is set by the shared mask unit, which reads one dominator row per cycle.
// Reset (rst, synchronous): edge and frontier stores cleared, block_count = 32,
// entry_block = 0, no result pending.
module dominator_and_frontier_sets
  import domfr_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration writes
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  // Edge stream; tdata: from_block [4:0], to_block [9:5], zeros [15:10]
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tlast,
  // Result stream; tdata: block_index [4:0], dominator_mask [36:5],
  // frontier_mask [68:37], zeros [71:69]; tuser: error_flag
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  localparam int unsigned ROWS = (MAX_BLOCKS < MASK_W) ? MAX_BLOCKS : MASK_W;
  localparam int unsigned IW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [CNT_W-1:0] ROWS_C = CNT_W'(ROWS);

  // Configuration registers
  logic [CNT_W-1:0] block_count;
  logic [IDX_W-1:0] entry_block;

  // Stores
  logic [MASK_W-1:0] pred_matrix [ROWS];
  logic [MASK_W-1:0] dom_matrix  [ROWS];
  logic [MASK_W-1:0] front_col   [ROWS];  // column b: blocks whose frontier holds b

  // Sequencer registers
  state_t            state, state_next;
  logic [IW-1:0]     blk;
  logic [IW-1:0]     pidx;
  logic              front_phase;
  logic              changed;
  logic              err;
  logic [MASK_W-1:0] acc;
  logic [MASK_W-1:0] cur;
  logic [MASK_W-1:0] preds;

  // Derived values
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  n_last;
  logic [MASK_W-1:0] full;
  logic [MASK_W-1:0] blk_bit;
  logic [MASK_W-1:0] pred_row;
  logic [MASK_W-1:0] dom_rd;
  logic [MASK_W-1:0] front_gather;
  logic [MASK_W-1:0] acc_new;
  logic [MASK_W-1:0] dom_new;
  logic [IW-1:0]     rd_idx;
  logic [IDX_W-1:0]  from_blk;
  logic [IDX_W-1:0]  to_blk;
  logic              in_xfer;
  logic              edge_ok;
  logic              blk_last;
  logic              p_last;
  logic              blk_entry;
  logic              skip_blk;
  logic              dom_diff;
  logic              changed_now;
  logic              emit_go;
  alu_ctl_t          alu_ctl;

  // Clamp the block count to 1..ROWS
  always_comb begin
    if (block_count > ROWS_C) begin
      n_eff = ROWS_C;
    end else if (block_count == '0) begin
      n_eff = CNT_W'(1);
    end else begin
      n_eff = block_count;
    end
    n_last = n_eff - CNT_W'(1);
    for (int i = 0; i < MASK_W; i++) begin
      full[i] = (CNT_W'(i) < n_eff);
    end
  end

  assign from_blk  = s_tdata[IDX_W-1:0];
  assign to_blk    = s_tdata[2*IDX_W-1:IDX_W];
  assign in_xfer   = s_tvalid && s_tready;
  assign edge_ok   = ({1'b0, from_blk} < n_eff) && ({1'b0, to_blk} < n_eff);
  assign blk_bit   = MASK_W'(1) << blk;
  assign blk_last  = (CNT_W'(blk) == n_last);
  assign p_last    = (CNT_W'(pidx) == n_last);
  assign blk_entry = (CNT_W'(blk) == {1'b0, entry_block});
  assign pred_row  = pred_matrix[blk] & full;
  assign skip_blk  = (pred_row == '0) || (!front_phase && blk_entry);
  assign dom_new   = acc | blk_bit;
  assign dom_diff  = (dom_new != cur);
  assign changed_now = changed || (!front_phase && dom_diff);
  assign emit_go   = !m_tvalid || m_tready;

  // Single read port on the dominator rows
  assign rd_idx = (state == S_SCAN) ? pidx : blk;
  assign dom_rd = dom_matrix[rd_idx];

  // Gather the frontier row of the current block from the columns
  always_comb begin
    front_gather = '0;
    for (int i = 0; i < ROWS; i++) begin
      front_gather[i] = front_col[i][blk];
    end
  end

  // Shared mask unit
  assign alu_ctl.take  = preds[pidx];
  assign alu_ctl.front = front_phase;

  domfr_alu u_alu (
    .ctl     (alu_ctl),
    .acc     (acc),
    .operand (dom_rd),
    .strict  (cur & ~blk_bit),
    .result  (acc_new)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer && s_tlast) state_next = S_INIT;
      end
      S_INIT: state_next = S_LOAD;
      S_LOAD: begin
        if (!skip_blk) begin
          state_next = S_SCAN;
        end else if (blk_last && front_phase) begin
          state_next = S_EMIT;
        end
      end
      S_SCAN: begin
        if (p_last) state_next = S_WRITE;
      end
      S_WRITE: begin
        if (blk_last && front_phase) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_EMIT: begin
        if (emit_go && blk_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_tready = (state == S_IDLE);
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCK_COUNT_RST;
      entry_block <= ENTRY_BLOCK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_COUNT: block_count <= cfg_data;
        REG_ENTRY_BLOCK: entry_block <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      blk         <= '0;
      pidx        <= '0;
      front_phase <= 1'b0;
      changed     <= 1'b0;
      err         <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          blk         <= '0;
          front_phase <= 1'b0;
          changed     <= 1'b0;
          err         <= 1'b0;
        end
        S_LOAD: begin
          pidx <= '0;
          if (!front_phase && !blk_entry && pred_row == '0) err <= 1'b1;
          if (skip_blk) begin
            if (!blk_last) begin
              blk <= blk + IW'(1);
            end else begin
              blk <= '0;
              changed <= 1'b0;
              if (!front_phase && !changed) front_phase <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          pidx <= pidx + IW'(1);
        end
        S_WRITE: begin
          if (!blk_last) begin
            blk     <= blk + IW'(1);
            changed <= changed_now;
          end else begin
            blk     <= '0;
            changed <= 1'b0;
            if (!front_phase && !changed_now) front_phase <= 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_go) blk <= blk_last ? '0 : blk + IW'(1);
        end
        default: ;
      endcase
    end
  end

  // Working registers of the current block
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        cur   <= dom_rd;
        preds <= pred_row;
        acc   <= front_phase ? '0 : full;
      end
      S_SCAN: acc <= acc_new;
      default: ;
    endcase
  end

  // Dominator rows: initialize, then update on change
  always_ff @(posedge clk) begin
    if (state == S_INIT) begin
      for (int i = 0; i < ROWS; i++) begin
        if (CNT_W'(i) == {1'b0, entry_block}) begin
          dom_matrix[i] <= MASK_W'(1) << i;
        end else begin
          dom_matrix[i] <= full & {MASK_W{CNT_W'(i) < n_eff}};
        end
      end
    end else if (state == S_WRITE && !front_phase && dom_diff) begin
      dom_matrix[blk] <= dom_new;
    end
  end

  // Edge store and frontier columns; drop both after the final result
  always_ff @(posedge clk) begin
    if (rst || (state == S_EMIT && emit_go && blk_last)) begin
      for (int i = 0; i < ROWS; i++) begin
        pred_matrix[i] <= '0;
        front_col[i]   <= '0;
      end
    end else begin
      if (in_xfer && edge_ok) begin
        pred_matrix[to_blk[IW-1:0]] <= pred_matrix[to_blk[IW-1:0]] |
                                       (MASK_W'(1) << from_blk);
      end
      if (state == S_WRITE && front_phase) front_col[blk] <= acc;
    end
  end

  // Result register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_EMIT && emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_go) begin
      m_tdata <= {3'b000, front_gather, dom_rd, IDX_W'(blk)};
      m_tuser <= err;
      m_tlast <= blk_last;
    end
  end

endmodule
